[rtl/core/assert_macros.svh]
// assertion helpers for the scheduler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property must hold at each clock edge outside reset
`define AST_HOLD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a condition implies another in the next cycle
`define AST_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/core/aps_pkg.sv]
package aps_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int RATE_W     = 12;
	localparam int TIME_W     = 32;
	localparam int PROD_W     = RATE_W + TIME_W;
	localparam int SCORE_W    = PROD_W - 8 + 1;

	localparam logic       OP_ARRIVE   = 1'b0;
	localparam logic       OP_TICK     = 1'b1;
	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_RAN    = 2'd2;
	localparam logic [1:0] KIND_IDLE   = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  task_id;
		logic [7:0]  static_prio;
		logic [15:0] duration;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  ran_task_id;
		logic        finished;
		logic [31:0] response_time;
		logic [31:0] turnaround_time;
		logic [31:0] waiting_time;
		logic [31:0] tick_time;
	} res_item_t;

	typedef struct packed {
		logic [7:0]  ident;
		logic [7:0]  priority_base;
		logic [31:0] arrival;
		logic [15:0] length;
		logic [15:0] remaining;
		logic        started;
		logic [31:0] first_start;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

endpackage

[rtl/core/aging_priority_preemptive_scheduler_top.sv]
// arrival: the ARR state accepts or rejects the item and registers its result
// tick with nothing ready: idle result, or one slice of the running task; otherwise
//   scans the ready entries, closes the queue gap, compares any running task, then runs the winner
// throughput: one item at a time; busy falls in the cycle its result is strobed
// the ready scan reads queue then slot memory per entry, then computes and compares its aged score
// reset: asynchronous, clears time, slot valid bits, queue count, running task and alpha;
//   results cannot be stalled: each result is on the ports for one cycle
module aging_priority_preemptive_scheduler_top import aps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          cmd,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [RATE_W-1:0] cfg_data,
	output logic              result_valid,
	output res_item_t         result
);

	`include "assert_macros.svh"

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ARR   = 4'd1;
	localparam logic [3:0] ST_ORD   = 4'd2;
	localparam logic [3:0] ST_REC   = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_CMP   = 4'd5;
	localparam logic [3:0] ST_SHRD  = 4'd6;
	localparam logic [3:0] ST_SHWR  = 4'd7;
	localparam logic [3:0] ST_RREC  = 4'd8;
	localparam logic [3:0] ST_RMUL  = 4'd9;
	localparam logic [3:0] ST_RCMP  = 4'd10;
	localparam logic [3:0] ST_RUNRD = 4'd11;
	localparam logic [3:0] ST_RUNWR = 4'd12;

	logic [3:0]           state_q;
	in_item_t             item_q;
	logic [RATE_W-1:0]    rate_q;
	logic [TIME_W-1:0]    now_q;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]     count_q;
	logic [SLOT_W-1:0]    run_slot_q;
	logic                 run_valid_q;
	logic [CNT_W-1:0]     pos_q;
	logic [SCORE_W-1:0]   best_q;
	logic [CNT_W-1:0]     best_pos_q;
	logic [SLOT_W-1:0]    best_slot_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	res_item_t            res_q;
	logic                 res_valid_q;

	logic                 ord_we;
	logic [SLOT_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic                 rec_we;
	logic [SLOT_W-1:0]    rec_waddr, rec_raddr;
	slot_rec_t            rec_wdata, rec_rdata;
	logic                 sc_load;
	logic [SCORE_W-1:0]   score;
	logic                 res_fire;
	res_item_t            res_next;

	logic [SLOT_W-1:0]    free_slot;
	logic                 full;
	logic                 win;
	logic [CNT_W-1:0]     pos_inc;
	logic [15:0]          rem_dec;
	logic [TIME_W-1:0]    fs_time, turn;

	aps_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	aps_ram #(.WIDTH(REC_W), .DEPTH(TASK_SLOTS)) u_slots (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rdata)
	);

	aps_score u_score (
		.clk(clk), .load(sc_load), .rate(rate_q), .now(now_q),
		.arrival(rec_rdata.arrival), .prio(rec_rdata.priority_base), .score(score)
	);

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		free_slot = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign full    = &valid_q;
	assign win     = (pos_q == '0) || (score > best_q);
	assign pos_inc = pos_q + CNT_W'(1);
	assign rem_dec = rec_rdata.remaining - 16'd1;
	assign fs_time = rec_rdata.started ? rec_rdata.first_start : now_q;
	assign turn    = now_q + 32'd1 - rec_rdata.arrival;

	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = count_q[SLOT_W-1:0];
		ord_wdata = best_slot_q;
		ord_raddr = pos_q[SLOT_W-1:0];
		rec_we    = 1'b0;
		rec_waddr = run_slot_q;
		rec_wdata = rec_rdata;
		rec_raddr = run_slot_q;
		sc_load   = 1'b0;
		res_fire  = 1'b0;
		res_next  = '0;
		case (state_q)
			ST_ARR: begin
				res_fire             = 1'b1;
				res_next.ran_task_id = item_q.task_id;
				res_next.tick_time   = now_q;
				res_next.result_kind = KIND_REJECT;
				if (item_q.duration != 16'd0 && !full) begin
					res_next.result_kind = KIND_ACCEPT;
					ord_we    = 1'b1;
					ord_wdata = free_slot;
					rec_we    = 1'b1;
					rec_waddr = free_slot;
					rec_wdata = '{ident: item_q.task_id, priority_base: item_q.static_prio,
						arrival: now_q, length: item_q.duration,
						remaining: item_q.duration, started: 1'b0, first_start: '0};
				end
			end
			ST_REC: begin
				rec_raddr = ord_rdata;
			end
			ST_MUL, ST_RMUL: begin
				sc_load = 1'b1;
			end
			ST_SHRD: begin
				ord_raddr = pos_inc[SLOT_W-1:0];
			end
			ST_SHWR: begin
				ord_we    = 1'b1;
				ord_waddr = pos_q[SLOT_W-1:0];
				ord_wdata = ord_rdata;
			end
			ST_RCMP: begin
				ord_we    = 1'b1;
				ord_wdata = (best_q > score) ? run_slot_q : best_slot_q;
			end
			ST_RUNRD: begin
				if (!run_valid_q) begin
					res_fire             = 1'b1;
					res_next.result_kind = KIND_IDLE;
					res_next.tick_time   = now_q;
				end
			end
			ST_RUNWR: begin
				rec_we                = 1'b1;
				rec_wdata.started     = 1'b1;
				rec_wdata.first_start = fs_time;
				rec_wdata.remaining   = rem_dec;
				res_fire              = 1'b1;
				res_next.result_kind  = KIND_RAN;
				res_next.ran_task_id  = rec_rdata.ident;
				res_next.tick_time    = now_q;
				if (rem_dec == 16'd0) begin
					res_next.finished        = 1'b1;
					res_next.response_time   = fs_time - rec_rdata.arrival;
					res_next.turnaround_time = turn;
					res_next.waiting_time    = turn - 32'(rec_rdata.length);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= '0;
			now_q       <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_fire;
			if (res_fire) begin
				res_q <= res_next;
			end
			if (cfg_valid && cfg_ready) begin
				rate_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= cmd;
						pos_q  <= '0;
						if (cmd.opcode == OP_ARRIVE) begin
							state_q <= ST_ARR;
						end else if (count_q != '0) begin
							state_q <= ST_ORD;
						end else begin
							state_q <= ST_RUNRD;
						end
					end
				end
				ST_ARR: begin
					if (item_q.duration != 16'd0 && !full) begin
						valid_q[free_slot] <= 1'b1;
						count_q            <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_ORD: begin
					state_q <= ST_REC;
				end
				ST_REC: begin
					cur_slot_q <= ord_rdata;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (win) begin
						best_q      <= score;
						best_pos_q  <= pos_q;
						best_slot_q <= cur_slot_q;
					end
					if (pos_inc < count_q) begin
						pos_q   <= pos_inc;
						state_q <= ST_ORD;
					end else begin
						pos_q   <= win ? pos_q : best_pos_q;
						state_q <= ST_SHRD;
					end
				end
				ST_SHRD: begin
					if (pos_inc < count_q) begin
						state_q <= ST_SHWR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_RREC;
					end
				end
				ST_SHWR: begin
					pos_q   <= pos_inc;
					state_q <= ST_SHRD;
				end
				ST_RREC: begin
					if (run_valid_q) begin
						state_q <= ST_RMUL;
					end else begin
						run_slot_q  <= best_slot_q;
						run_valid_q <= 1'b1;
						state_q     <= ST_RUNRD;
					end
				end
				ST_RMUL: begin
					state_q <= ST_RCMP;
				end
				ST_RCMP: begin
					// strictly higher score preempts
					if (best_q > score) begin
						run_slot_q <= best_slot_q;
					end
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_RUNRD;
				end
				ST_RUNRD: begin
					if (run_valid_q) begin
						state_q <= ST_RUNWR;
					end else begin
						now_q   <= now_q + 32'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_RUNWR: begin
					if (rem_dec == 16'd0) begin
						valid_q[run_slot_q] <= 1'b0;
						run_valid_q         <= 1'b0;
					end
					now_q   <= now_q + 32'd1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`AST_HOLD(a_count_bound, count_q <= CNT_W'(TASK_SLOTS), "ready count beyond slot count")
	`AST_HOLD(a_run_slot_valid, !run_valid_q || valid_q[run_slot_q], "running slot not occupied")
	`AST_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
	`AST_HOLD(a_result_src, !result_valid || $past(state_q == ST_ARR || state_q == ST_RUNRD || state_q == ST_RUNWR), "result strobe from wrong state")

endmodule

[rtl/core/aps_ram.sv]
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/aps_score.sv]
module aps_score import aps_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic [RATE_W-1:0]  rate,
	input  logic [TIME_W-1:0]  now,
	input  logic [TIME_W-1:0]  arrival,
	input  logic [7:0]         prio,
	output logic [SCORE_W-1:0] score
);

	logic [PROD_W-1:0] prod_q;
	logic [7:0]        prio_q;
	logic [TIME_W-1:0] age;

	assign age = now - arrival;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_W'(rate) * PROD_W'(age);
			prio_q <= prio;
		end
	end

	// base plus floor(alpha * age)
	assign score = SCORE_W'(prod_q[PROD_W-1:8]) + SCORE_W'(prio_q);

endmodule
